@@ hw/rtl/xsbr_pkg.sv @@
// ----------------------------------------------------------------------------
// xsbr_pkg: shared types and constants for the bounded random source
// Widths, op codes, shift amounts and seed reset values.
// ----------------------------------------------------------------------------
package xsbr_pkg;

  localparam int unsigned WordW    = 64;  // generator state word / result width
  localparam int unsigned HalfW    = 32;  // upper half of a draw fed to the scaler
  localparam int unsigned MaxW     = 31;  // bound width
  localparam int unsigned NumWords = 4;   // state words
  localparam int unsigned ProdW    = MaxW + HalfW;

  localparam int unsigned RotRes   = 7;   // rotate inside the output scrambler
  localparam int unsigned ShlT     = 17;  // state shift term
  localparam int unsigned RotS3    = 45;  // rotate of word 3
  localparam int unsigned FracSh   = 11;  // 64 -> 53 bit fraction numerator

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] seed_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DRAW  = 2'd1,
    OP_BOUND = 2'd2,
    OP_FRAC  = 2'd3
  } op_e;

  typedef enum logic {
    ST_OK     = 1'b0,
    ST_ZSEED  = 1'b1
  } status_e;

  localparam word_t SeedRst0 = 64'd1;
  localparam word_t SeedRst1 = 64'd0;
  localparam word_t SeedRst2 = 64'd0;
  localparam word_t SeedRst3 = 64'd0;

  typedef struct packed {
    logic            start;  // begin a threshold computation
    logic [MaxW-1:0] bound;  // divisor, >= 2
  } rem_req_t;

  typedef struct packed {
    logic            done;   // one-cycle pulse, rem valid
    logic [MaxW-1:0] rem;    // (2^32 - bound) mod bound
  } rem_rsp_t;

endpackage

@@ hw/rtl/xoshiro256ss_bounded_random.sv @@
// ----------------------------------------------------------------------------
// xoshiro256ss_bounded_random: xoshiro256** source with bounded draws
// Load goes straight to the result beat; raw and fraction draws pass both
// steps of the scrambler's shared adder; a bounded draw adds scaling and a
// check, repeats it all per redraw and, when needed, has the serial unit work
// out the rejection threshold once per item. Bounds 0 and 1 skip the steps.
// One item in flight. The next item is taken while a result beat waits.
// Reset loads seeds and state with 1, 0, 0, 0; no clearing pass.
// ----------------------------------------------------------------------------
module xoshiro256ss_bounded_random (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: seed registers
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [xsbr_pkg::WordW-1:0]   cfg_wdata_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [xsbr_pkg::MaxW-1:0]    max_value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [xsbr_pkg::WordW-1:0]   value_o,
  output logic                         status_o
);
  import xsbr_pkg::*;

  // seed registers; state only picks them up on a load op
  seed_t    seed_q;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= {SeedRst3, SeedRst2, SeedRst1, SeedRst0};
    end else if (cfg_we_i) begin
      seed_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // sequencer, generator state and result beat register
  xsbr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .max_value_i (max_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .rem_req_o   (rem_req),
    .rem_rsp_i   (rem_rsp)
  );

  // (2^32 - bound) mod bound, computed on the first near-miss of an item
  xsbr_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

endmodule

@@ hw/rtl/xsbr_rem.sv @@
// ----------------------------------------------------------------------------
// xsbr_rem: bit-serial rejection threshold unit
// Computes (2^32 - bound) mod bound, one restoring step per cycle.
// ----------------------------------------------------------------------------
module xsbr_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xsbr_pkg::rem_req_t req_i,
  output xsbr_pkg::rem_rsp_t rsp_o
);
  import xsbr_pkg::*;

  localparam int unsigned CntW = $clog2(HalfW);

  logic [HalfW-1:0] r_q, n_q, sh, r_d;
  logic [MaxW-1:0]  d_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic             ge;

  always_comb begin
    sh  = {r_q[HalfW-2:0], n_q[HalfW-1]};
    ge  = (sh >= {1'b0, d_q});
    r_d = ge ? (sh - {1'b0, d_q}) : sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse after the last restoring step
      done_q <= busy_q && !req_i.start && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(HalfW - 1);
        d_q    <= req_i.bound;
        n_q    <= HalfW'(0) - {1'b0, req_i.bound};
        r_q    <= '0;
      end else if (busy_q) begin
        r_q   <= r_d;
        n_q   <= {n_q[HalfW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // remainder stays below the divisor, so the top bit is always clear
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q[MaxW-1:0];

endmodule

@@ hw/rtl/xsbr_core.sv @@
// ----------------------------------------------------------------------------
// xsbr_core: generator state, shared scrambler adder and op sequencer
// Steps xoshiro256**, scales draws for bounded ops and holds the result beat.
// ----------------------------------------------------------------------------
module xsbr_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  xsbr_pkg::seed_t         seed_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic [xsbr_pkg::MaxW-1:0] max_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [xsbr_pkg::WordW-1:0] value_o,
  output logic                    status_o,
  output xsbr_pkg::rem_req_t      rem_req_o,
  input  xsbr_pkg::rem_rsp_t      rem_rsp_i
);
  import xsbr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL5, S_MUL9, S_SCALE, S_CHECK, S_REMW, S_DONE
  } state_e;

  state_e          state_q;
  seed_t           st_q, st_d;
  word_t           acc_q, res_q, out_value_q;
  logic            stat_q, out_status_q, out_valid_q;
  op_e             op_q;
  logic [MaxW-1:0] bound_q, thr_q;
  logic            thr_vld_q;
  logic [ProdW-1:0] prod_q, prod_d;

  word_t           add_a, add_b, sum, rot_acc, t_term, x2, x3;
  logic [HalfW-1:0] low;
  logic            low_lt_bound, low_lt_thr, seed_zero, out_free, out_load;

  function automatic word_t rotl(input word_t x, input int unsigned k);
    return (x << k) | (x >> (WordW - k));
  endfunction

  always_comb begin
    // shared adder: x*5 in S_MUL5, rotl(x,7)*9 in S_MUL9
    rot_acc = rotl(acc_q, RotRes);
    if (state_q == S_MUL9) begin
      add_a = rot_acc;
      add_b = rot_acc << 3;
    end else begin
      add_a = st_q[1];
      add_b = st_q[1] << 2;
    end
    sum = add_a + add_b;

    // state transition
    t_term = st_q[1] << ShlT;
    x2     = st_q[2] ^ st_q[0];
    x3     = st_q[3] ^ st_q[1];
    st_d[1] = st_q[1] ^ x2;
    st_d[0] = st_q[0] ^ x3;
    st_d[2] = x2 ^ t_term;
    st_d[3] = rotl(x3, RotS3);

    prod_d       = ProdW'(bound_q) * ProdW'(acc_q[WordW-1:HalfW]);
    low          = prod_q[HalfW-1:0];
    low_lt_bound = (low < {1'b0, bound_q});
    low_lt_thr   = (low < {1'b0, thr_q});
    seed_zero    = (seed_i == '0);
    out_free     = !out_valid_q || out_ready_i;
    out_load     = (state_q == S_DONE) && out_free;

    rem_req_o.start = (state_q == S_CHECK) && low_lt_bound && !thr_vld_q;
    rem_req_o.bound = bound_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= {SeedRst3, SeedRst2, SeedRst1, SeedRst0};
      out_valid_q <= 1'b0;
      thr_vld_q   <= 1'b0;
    end else begin
      if (out_load)                        out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_e'(op_i);
            bound_q <= max_value_i;
            res_q   <= '0;
            stat_q  <= (op_e'(op_i) == OP_LOAD && seed_zero) ? ST_ZSEED : ST_OK;
            thr_vld_q <= 1'b0;
            case (op_e'(op_i))
              OP_LOAD: begin
                // an all-zero seed is refused and the state kept
                if (!seed_zero) st_q <= seed_i;
                state_q <= S_DONE;
              end
              OP_BOUND: begin
                // bounds 0 and 1 answer 0 without stepping
                state_q <= (max_value_i <= MaxW'(1)) ? S_DONE : S_MUL5;
              end
              default: state_q <= S_MUL5;
            endcase
          end
        end
        S_MUL5: begin
          acc_q   <= sum;
          st_q    <= st_d;
          state_q <= S_MUL9;
        end
        S_MUL9: begin
          acc_q <= sum;
          case (op_q)
            OP_FRAC: begin
              res_q   <= sum >> FracSh;
              state_q <= S_DONE;
            end
            OP_BOUND: state_q <= S_SCALE;
            default: begin
              res_q   <= sum;
              state_q <= S_DONE;
            end
          endcase
        end
        S_SCALE: begin
          prod_q  <= prod_d;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!low_lt_bound || (thr_vld_q && !low_lt_thr)) begin
            res_q   <= {{(WordW-MaxW){1'b0}}, prod_q[ProdW-1:HalfW]};
            state_q <= S_DONE;
          end else if (!thr_vld_q) begin
            state_q <= S_REMW;
          end else begin
            state_q <= S_MUL5;  // rejected, redraw
          end
        end
        S_REMW: begin
          if (rem_rsp_i.done) begin
            thr_q     <= rem_rsp_i.rem;
            thr_vld_q <= 1'b1;
            state_q   <= S_CHECK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_value_q  <= res_q;
            out_status_q <= stat_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  a_thr_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && thr_vld_q) |-> (thr_q < bound_q))
    else $error("threshold not below bound");

  a_mul9_after_mul5: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL9) |-> ($past(state_q) == S_MUL5))
    else $error("scrambler second step out of order");

  a_rem_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp_i.done |-> (state_q == S_REMW))
    else $error("threshold done outside wait");

  a_bounded_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q == OP_BOUND && bound_q > MaxW'(1))
      |-> (res_q < {{(WordW-MaxW){1'b0}}, bound_q}))
    else $error("bounded result out of range");

endmodule

@@ verif/xoshiro256ss_bounded_random_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xoshiro256ss_bounded_random_tb: self-checking bench for the bounded source
// Drives seed writes and request beats with random gaps and result stalls.
// An in-bench model of the generator predicts every result beat, and each
// returned beat is compared in order against that prediction.
// ----------------------------------------------------------------------------
module xoshiro256ss_bounded_random_tb;
  import xsbr_pkg::*;

  localparam int unsigned StallLimit = 4000;  // cycles without any accepted beat
  localparam int unsigned DrainWait  = 60;    // settle time after the last result
  localparam int unsigned RandPhases = 6;
  localparam int unsigned PhaseItems = 265;

  typedef struct {
    word_t   value;
    status_e status;
  } draw_result_t;

  // --------------------------------------------------------------------------
  // Generator model plus the in-order store of predicted result beats.
  // Seeds are mirrored on every register write; state only moves on requests.
  // --------------------------------------------------------------------------
  class draw_checker;
    word_t        seed_copy [NumWords];
    word_t        gen_state [NumWords];
    draw_result_t expected_draws[$];
    int           errors;

    function new();
      seed_copy = '{SeedRst0, SeedRst1, SeedRst2, SeedRst3};
      gen_state = seed_copy;
      errors    = 0;
    endfunction

    function void set_seed(int unsigned idx, word_t value);
      seed_copy[idx] = value;
    endfunction

    static function word_t rotl64(word_t x, int unsigned k);
      return (x << k) | (x >> (WordW - k));
    endfunction

    // one xoshiro256** step: scrambled output from word 1, then state update
    function word_t next_draw();
      word_t s0, s1, s2, s3, scr, t;
      s0  = gen_state[0];
      s1  = gen_state[1];
      s2  = gen_state[2];
      s3  = gen_state[3];
      scr = s1 * 64'd5;
      scr = rotl64(scr, RotRes) * 64'd9;
      t   = s1 << ShlT;
      s2  = s2 ^ s0;
      s3  = s3 ^ s1;
      s1  = s1 ^ s2;
      s0  = s0 ^ s3;
      s2  = s2 ^ t;
      s3  = rotl64(s3, RotS3);
      gen_state = '{s0, s1, s2, s3};
      return scr;
    endfunction

    // multiply-shift on the upper half; threshold only worked out when the
    // low product falls below the bound, then redraw while under it
    function word_t bounded_draw(logic [MaxW-1:0] bound);
      logic [HalfW-1:0] b32, low, thr;
      logic [63:0]      prod;
      word_t            d;
      if (bound <= 1) return '0;
      b32  = {1'b0, bound};
      d    = next_draw();
      prod = {32'd0, b32} * {32'd0, d[63:32]};
      low  = prod[31:0];
      if (low < b32) begin
        thr = (32'd0 - b32) % b32;
        while (low < thr) begin
          d    = next_draw();
          prod = {32'd0, b32} * {32'd0, d[63:32]};
          low  = prod[31:0];
        end
      end
      return word_t'(prod[63:32]);
    endfunction

    function void note_request(op_e op, logic [MaxW-1:0] bound);
      draw_result_t r;
      r.value  = '0;
      r.status = ST_OK;
      case (op)
        OP_LOAD: begin
          if ((seed_copy[0] | seed_copy[1] | seed_copy[2] | seed_copy[3]) == '0)
            r.status = ST_ZSEED;  // refused, state kept
          else
            gen_state = seed_copy;
        end
        OP_DRAW:  r.value = next_draw();
        OP_BOUND: r.value = bounded_draw(bound);
        default:  r.value = next_draw() >> FracSh;
      endcase
      expected_draws.push_back(r);
    endfunction

    function void check_result(word_t value, logic status);
      draw_result_t want;
      if (expected_draws.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: value=%h status=%0d", value, status);
        return;
      end
      want = expected_draws.pop_front();
      if (value !== want.value || status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                   want.value, want.status, value, status);
      end
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [WordW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          op_i;
  logic [MaxW-1:0]     max_value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [WordW-1:0]    value_o;
  logic                status_o;

  xoshiro256ss_bounded_random uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .max_value_i (max_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  draw_checker sb = new();
  bit          steady_flow = 1'b0;  // set: neither side idles
  int unsigned quiet_cycles = 0;

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side backpressure: ready drops about a third of the time.
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Result monitor. Sampled at the edge, so it sees the pre-edge values the
  // DUT itself used for the handshake.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(value_o, status_o);
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present one request beat, after random idle cycles, and hold it until
  // accepted. Valid stays high into the next call if that one does not idle.
  task automatic send_request(input op_e op, input logic [MaxW-1:0] bound);
    while (!steady_flow && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    max_value_i <= bound;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, bound);
  endtask

  // Every request yields a result, so an empty queue means the block is idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all four seed registers back to back; model mirrors them.
  task automatic write_seeds(input seed_t s);
    for (int i = 0; i < NumWords; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[1:0];
      cfg_wdata_i <= s[i];
      sb.set_seed(i, s[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic op_e rand_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6)  return OP_LOAD;
    if (r < 30) return OP_DRAW;
    if (r < 76) return OP_BOUND;
    return OP_FRAC;
  endfunction

  // Mix of degenerate, small, rejection-heavy and full-range bounds.
  function automatic logic [MaxW-1:0] rand_bound();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return MaxW'($urandom_range(1));
    if (r < 30) return MaxW'($urandom_range(1000, 2));
    if (r < 42) return MaxW'(32'h4000_0001 + $urandom_range(16'hffff));
    if (r < 55) return MaxW'(32'h5555_5556 - $urandom_range(16'hffff));
    return MaxW'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    seed_t seeds;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    op_i        <= OP_LOAD;
    max_value_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset seeds (1, 0, 0, 0).
    send_request(OP_DRAW,  '1);            // bound field ignored on raw draws
    send_request(OP_BOUND, '0);            // bound 0: zero, no step
    send_request(OP_BOUND, 31'd1);         // bound 1: zero, no step
    send_request(OP_BOUND, 31'd2);
    send_request(OP_BOUND, 31'h7fff_ffff); // largest bound
    send_request(OP_BOUND, 31'h5555_5556); // threshold near the bound: redraws
    send_request(OP_BOUND, 31'h4000_0001);
    send_request(OP_FRAC,  '0);
    send_request(OP_LOAD,  '0);            // reload reset seeds
    send_request(OP_FRAC,  '1);
    wait_drained();

    // all-zero seed is refused and the generator keeps running
    write_seeds('0);
    send_request(OP_LOAD, '0);
    send_request(OP_DRAW, '0);
    wait_drained();

    // seed writes alone must not disturb the state until a load
    write_seeds('1);
    send_request(OP_DRAW,  '0);
    send_request(OP_LOAD,  '1);
    send_request(OP_DRAW,  '0);
    send_request(OP_BOUND, 31'd3);
    send_request(OP_FRAC,  '0);
    wait_drained();

    seeds = '{64'd0, 64'd0, 64'd0, 64'h8000_0000_0000_0000};
    write_seeds(seeds);
    send_request(OP_LOAD,  '0);
    send_request(OP_BOUND, 31'h5555_5556);
    send_request(OP_BOUND, 31'h5555_5556);
    send_request(OP_DRAW,  '0);
    wait_drained();

    // Random phases, each with its own seed set. Phase 2 runs without any
    // idling on either side; phase 3 tries to load an all-zero seed.
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       seeds = '{64'd0, '1, '1, '1};
        3:       seeds = '0;
        default: seeds = '{rand_word(), rand_word(), rand_word(), rand_word()};
      endcase
      write_seeds(seeds);
      steady_flow = (ph == 2);
      if ($urandom_range(3) != 0) send_request(OP_LOAD, MaxW'($urandom()));
      for (int n = 0; n < PhaseItems; n++) send_request(rand_op(), rand_bound());
      wait_drained();
    end
    steady_flow = 1'b0;

    repeat (DrainWait) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d predicted results never arrived", sb.pending());
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ xoshiro256ss_bounded_random.f @@
hw/rtl/xsbr_pkg.sv
hw/rtl/xsbr_rem.sv
hw/rtl/xsbr_core.sv
hw/rtl/xoshiro256ss_bounded_random.sv
verif/xoshiro256ss_bounded_random_tb.sv
